// ----- design/indexed_min_heap_priority_queue_assert.svh -----
// Assertion macros shared by the heap queue checker.
// Depends on nothing; take in with `include.
`ifndef INDEXED_MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define INDEXED_MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, gated by reset.
`define IMHPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// Next-cycle implication, gated by reset.
`define IMHPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

// ----- design/imhpq_pkg.sv -----
// Types and codes for the indexed min-heap priority queue.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package imhpq_pkg;

    localparam int ID_BITS = 8;
    localparam int NUM_IDS = 256;

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_REMOVE   = 2'd1;
    localparam logic [1:0] CMD_DECREASE = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_ABSENT   = 3'd3;
    localparam logic [2:0] ST_PRESENT  = 3'd4;
    localparam logic [2:0] ST_INCREASE = 3'd5;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  item_id;
        logic [31:0] key_value;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  removed_id;
        logic [31:0] removed_key;
        logic [7:0]  min_id;
        logic [31:0] min_key;
        logic [8:0]  count;
        logic        empty_res;
    } rsp_t;

endpackage
`default_nettype wire

// ----- design/imhpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module imhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/indexed_min_heap_priority_queue.sv -----
// Insert climbs from the new last slot toward the root; decrease first reads the id's
// position and heap entry, then climbs; remove, unless it empties the queue, moves the
// last entry to the root and descends; full, empty, duplicate, absent id and key increase
// end early, and a held result adds its stall. One command at a time: req_ready is high
// only while idle, and each sift step waits on the single heap read port.
// Reset: count, sequencer and id-present bits clear at once; uses imhpq_pkg, imhpq_ram.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_priority_queue #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire imhpq_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output imhpq_pkg::rsp_t     rsp
);
    import imhpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = ID_BITS + KEY_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PM   = 4'd1;
    localparam logic [3:0] S_HP   = 4'd2;
    localparam logic [3:0] S_UCHK = 4'd3;
    localparam logic [3:0] S_UCMP = 4'd4;
    localparam logic [3:0] S_RMLD = 4'd5;
    localparam logic [3:0] S_DCHK = 4'd6;
    localparam logic [3:0] S_DL   = 4'd7;
    localparam logic [3:0] S_DR   = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] key;
    } entry_t;

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [NUM_IDS-1:0] vld_reg, vld_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;
    entry_t             cur_reg, cur_next;
    entry_t             lft_reg, lft_next;
    entry_t             root_reg, root_next;
    logic [CW-1:0]      p_reg, p_next;
    logic               has_r_reg, has_r_next;
    logic [2:0]         status_reg, status_next;
    logic [7:0]         rid_reg, rid_next;
    logic [31:0]        rkey_reg, rkey_next;

    logic               heap_we;
    logic [CW-1:0]      heap_wpos;
    entry_t             heap_wdata;
    logic [CW:0]        heap_rpos;
    entry_t             heap_rdata;
    logic               pm_we;
    logic [7:0]         pm_waddr;
    logic [CW-1:0]      pm_wdata;
    logic [7:0]         pm_raddr;
    logic [CW-1:0]      pm_rdata;

    logic [CW:0]        l_pos, r_pos, cnt_ext;
    logic               sel_l, sel_r;
    logic [KEY_BITS-1:0] best_key;

    imhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
        .clk   (clk),
        .we    (heap_we),
        .waddr (AW'(heap_wpos - 1'b1)),
        .wdata (heap_wdata),
        .raddr (AW'(heap_rpos - 1'b1)),
        .rdata (heap_rdata)
    );

    imhpq_ram #(.WIDTH(CW), .DEPTH(NUM_IDS)) u_pmap (
        .clk   (clk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign l_pos    = {p_reg, 1'b0};
    assign r_pos    = {p_reg, 1'b1};
    assign cnt_ext  = {1'b0, count_reg};
    assign sel_l    = lft_reg.key < cur_reg.key;
    assign best_key = sel_l ? lft_reg.key : cur_reg.key;
    assign sel_r    = has_r_reg && (heap_rdata.key < best_key);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        vld_next       = vld_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cur_next       = cur_reg;
        lft_next       = lft_reg;
        p_next         = p_reg;
        has_r_next     = has_r_reg;
        status_next    = status_reg;
        rid_next       = rid_reg;
        rkey_next      = rkey_reg;
        heap_we        = 1'b0;
        heap_wpos      = p_reg;
        heap_wdata     = cur_reg;
        heap_rpos      = {1'b0, p_reg};
        pm_we          = 1'b0;
        pm_waddr       = cur_reg.id;
        pm_wdata       = p_reg;
        pm_raddr       = req.item_id;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cur_next    = '{id: req.item_id, key: KEY_BITS'(req.key_value)};
                    status_next = ST_OK;
                    rid_next    = '0;
                    rkey_next   = '0;
                    state_next  = S_DONE;
                    case (req.command)
                        CMD_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (vld_reg[req.item_id])
                            begin
                                status_next = ST_PRESENT;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                p_next     = count_reg + 1'b1;
                                state_next = S_UCHK;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rid_next               = root_reg.id;
                                rkey_next              = 32'(root_reg.key);
                                vld_next[root_reg.id]  = 1'b0;
                                count_next             = count_reg - 1'b1;
                                heap_rpos              = cnt_ext;
                                if (count_reg != CW'(1))
                                begin
                                    state_next = S_RMLD;
                                end
                            end
                        end
                        CMD_DECREASE:
                        begin
                            state_next = S_PM;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_PM:
            begin
                if (!vld_reg[cur_reg.id])
                begin
                    status_next = ST_ABSENT;
                    state_next  = S_DONE;
                end
                else
                begin
                    p_next     = pm_rdata;
                    heap_rpos  = {1'b0, pm_rdata};
                    state_next = S_HP;
                end
            end
            S_HP:
            begin
                if (cur_reg.key > heap_rdata.key)
                begin
                    status_next = ST_INCREASE;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_UCHK;
                end
            end
            S_UCHK:
            begin
                if (p_reg == CW'(1))
                begin
                    heap_we            = 1'b1;
                    pm_we              = 1'b1;
                    vld_next[cur_reg.id] = 1'b1;
                    state_next         = S_DONE;
                end
                else
                begin
                    heap_rpos  = {1'b0, p_reg >> 1};
                    state_next = S_UCMP;
                end
            end
            S_UCMP:
            begin
                if (cur_reg.key < heap_rdata.key)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rdata;
                    pm_we      = 1'b1;
                    pm_waddr   = heap_rdata.id;
                    p_next     = p_reg >> 1;
                    state_next = S_UCHK;
                end
                else
                begin
                    heap_we            = 1'b1;
                    pm_we              = 1'b1;
                    vld_next[cur_reg.id] = 1'b1;
                    state_next         = S_DONE;
                end
            end
            S_RMLD:
            begin
                cur_next   = heap_rdata;
                p_next     = CW'(1);
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                if (l_pos > cnt_ext)
                begin
                    heap_we            = 1'b1;
                    pm_we              = 1'b1;
                    vld_next[cur_reg.id] = 1'b1;
                    state_next         = S_DONE;
                end
                else
                begin
                    heap_rpos  = l_pos;
                    state_next = S_DL;
                end
            end
            S_DL:
            begin
                lft_next   = heap_rdata;
                has_r_next = (r_pos <= cnt_ext);
                heap_rpos  = r_pos;
                state_next = S_DR;
            end
            S_DR:
            begin
                if (sel_r || sel_l)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = sel_r ? heap_rdata : lft_reg;
                    pm_we      = 1'b1;
                    pm_waddr   = sel_r ? heap_rdata.id : lft_reg.id;
                    p_next     = sel_r ? CW'(r_pos) : CW'(l_pos);
                    state_next = S_DCHK;
                end
                else
                begin
                    heap_we            = 1'b1;
                    pm_we              = 1'b1;
                    vld_next[cur_reg.id] = 1'b1;
                    state_next         = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status      = status_reg;
                    out_next.removed_id  = rid_reg;
                    out_next.removed_key = rkey_reg;
                    out_next.min_id      = (count_reg != '0) ? root_reg.id : '0;
                    out_next.min_key     = (count_reg != '0) ? 32'(root_reg.key) : '0;
                    out_next.count       = 9'(count_reg);
                    out_next.empty_res   = (count_reg == '0);
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        root_next = root_reg;
        if (heap_we && (heap_wpos == CW'(1)))
        begin
            root_next = heap_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        cur_reg    <= cur_next;
        lft_reg    <= lft_next;
        root_reg   <= root_next;
        p_reg      <= p_next;
        has_r_reg  <= has_r_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        rkey_reg   <= rkey_next;
    end

endmodule
`default_nettype wire

// ----- design/imhpq_checker.sv -----
// Port-level checks on the heap queue response channel, bound to the top level.
// Depends on imhpq_pkg and indexed_min_heap_priority_queue_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_min_heap_priority_queue_assert.svh"
module imhpq_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            rsp_valid,
    input wire logic            rsp_ready,
    input wire imhpq_pkg::rsp_t rsp
);
    import imhpq_pkg::*;

    logic empty_ok;
    logic empty_shown;
    logic min_zero;
    logic is_error;
    logic removed_zero;

    assign empty_ok     = rsp.empty_res == (rsp.count == 9'd0);
    assign empty_shown  = rsp_valid && rsp.empty_res;
    assign min_zero     = (rsp.min_id == 8'd0) && (rsp.min_key == 32'd0);
    assign is_error     = rsp_valid && (rsp.status != ST_OK);
    assign removed_zero = (rsp.removed_id == 8'd0) && (rsp.removed_key == 32'd0);

    `IMHPQ_ASSERT_IMP(a_empty_flag, clk, rst_n, rsp_valid, empty_ok)
    `IMHPQ_ASSERT_IMP(a_empty_min, clk, rst_n, empty_shown, min_zero)
    `IMHPQ_ASSERT_IMP(a_err_removed, clk, rst_n, is_error, removed_zero)
    `IMHPQ_ASSERT_IMP(a_status_code, clk, rst_n, rsp_valid, rsp.status <= ST_INCREASE)
    `IMHPQ_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind indexed_min_heap_priority_queue imhpq_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
`default_nettype wire
